/* design/tsbq_pkg.sv */
// ----------------------------------------------------------------------------
// tsbq_pkg
// shared types and constants of the two-stack bounded queue
// ----------------------------------------------------------------------------
package tsbq_pkg;

	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_DATA_WIDTH  = 32;

	localparam int          CAP_W     = 7;
	localparam logic [6:0]  CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		op_t                opcode;
		logic signed [31:0] push_value;
		logic [6:0]         read_index;
	} req_t;

	typedef struct packed {
		logic signed [31:0] data_out;
		status_t            status;
		logic [7:0]         item_count;
		logic               is_full;
	} rsp_t;

endpackage

/* design/tsbq_ram.sv */
// ----------------------------------------------------------------------------
// tsbq_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tsbq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// read data holds while no read is issued
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/two_stack_bounded_queue.sv */
// ----------------------------------------------------------------------------
// two_stack_bounded_queue
// fifo queue with two-stack semantics: push, pop and indexed read
// ----------------------------------------------------------------------------
// usage
//  - req channel (valid/ready): one transaction carries opcode, push_value and
//    read_index; every transaction yields exactly one rsp transaction
//  - rsp channel (valid/ready): data_out, status, item_count, is_full
//  - cfg channel (valid/ready): writes stack_capacity, always ready; only
//    write it while the queue has no transaction in flight
//  - a request passes stage 1 (the ring read) and then the output register;
//    rsp_valid rises as it enters the output register
//  - throughput: one transaction per cycle while rsp_ready stays high; both
//    stacks live in one ring memory, so a stack transfer is only a change of
//    counts, and a pop or a read costs one read of the ring's registered port
//  - a stalled rsp holds its output register; one further request waits in
//    the middle stage, then req_ready drops until rsp_ready returns
//  - reset empties both stacks and sets the capacity to 64; memory contents
//    are never read before they are written, so no clearing pass is needed
// ----------------------------------------------------------------------------
module two_stack_bounded_queue import tsbq_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	// count width, ring address width, total width, compare widths
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(2 * STACK_DEPTH);
	localparam int TW = $clog2(2 * STACK_DEPTH + 1);
	localparam int XW = (TW > 7) ? TW : 7;
	localparam int KW = (CW > CAP_W) ? CW : CAP_W;
	localparam int RING_DEPTH = 2 ** AW;

	// architectural state
	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    in_cnt_q;
	logic [CW-1:0]    out_cnt_q;
	logic [AW-1:0]    head_q;

	// stage 1: waiting for the ring read data
	logic             v_s1;
	status_t          st_s1;
	logic             rd_s1;
	logic [7:0]       cnt_s1;
	logic             full_s1;

	// output register
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	// combinational
	logic [KW-1:0]    cap_k;
	logic [KW-1:0]    cap_eff;
	logic             in_full;
	logic             accept;
	logic             s1_adv;
	logic [CW-1:0]    in_nx;
	logic [CW-1:0]    out_nx;
	logic [AW-1:0]    head_nx;
	logic [TW-1:0]    total;
	logic [TW-1:0]    total_nx;
	status_t          status;
	logic             re;
	logic             we;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    waddr;
	logic [63:0]      push_ext;
	logic [DATA_WIDTH-1:0] wdata;
	logic [DATA_WIDTH-1:0] rdata;
	logic [63:0]      rd_ext;

	assign cfg_ready = 1'b1;

	// effective capacity, saturated into 1..STACK_DEPTH
	assign cap_k   = KW'(cap_q);
	assign cap_eff = (cap_q == '0) ? KW'(1) :
		(cap_k > KW'(STACK_DEPTH)) ? KW'(STACK_DEPTH) : cap_k;
	assign in_full = KW'(in_cnt_q) >= cap_eff;

	assign s1_adv    = v_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !v_s1 || s1_adv;
	assign accept    = req_valid && req_ready;

	assign total    = TW'(in_cnt_q) + TW'(out_cnt_q);
	assign total_nx = TW'(in_nx) + TW'(out_nx);

	// push data masked to the stored width
	assign push_ext = {32'd0, req.push_value};
	assign wdata    = push_ext[DATA_WIDTH-1:0];

	// ring layout: outbound elements oldest first from head, then inbound ones;
	// moving the inbound stack over only shifts the split between the counts
	always_comb begin
		in_nx   = in_cnt_q;
		out_nx  = out_cnt_q;
		head_nx = head_q;
		status  = ST_OK;
		re      = 1'b0;
		we      = 1'b0;
		raddr   = head_q;
		waddr   = head_q + AW'(in_cnt_q) + AW'(out_cnt_q);
		unique case (req.opcode)
			OP_PUSH: begin
				if (in_full && out_cnt_q != '0) begin
					status = ST_FULL;
				end else if (in_full) begin
					// full inbound, empty outbound: transfer, then push
					we     = 1'b1;
					out_nx = in_cnt_q;
					in_nx  = CW'(1);
				end else begin
					we    = 1'b1;
					in_nx = in_cnt_q + CW'(1);
				end
			end
			OP_POP: begin
				if (out_cnt_q == '0 && in_cnt_q == '0) begin
					status = ST_EMPTY;
				end else begin
					re      = 1'b1;
					head_nx = head_q + AW'(1);
					if (out_cnt_q == '0) begin
						// refill from the inbound stack first
						out_nx = in_cnt_q - CW'(1);
						in_nx  = '0;
					end else begin
						out_nx = out_cnt_q - CW'(1);
					end
				end
			end
			OP_READ: begin
				if (XW'(req.read_index) >= XW'(total)) begin
					status = ST_RANGE;
				end else begin
					re    = 1'b1;
					raddr = head_q + AW'(req.read_index);
				end
			end
			OP_NONE: begin
			end
		endcase
	end

	tsbq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (accept && we),
		.wr_addr (waddr),
		.wr_data (wdata),
		.rd_en   (accept && re),
		.rd_addr (raddr),
		.rd_data (rdata)
	);

	assign rd_ext = 64'(rdata);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// counts and ring head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			head_q    <= '0;
		end else if (accept) begin
			in_cnt_q  <= in_nx;
			out_cnt_q <= out_nx;
			head_q    <= head_nx;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	// stage 1 payload, status and post-operation occupancy
	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1   <= status;
			rd_s1   <= re;
			cnt_s1  <= 8'(total_nx);
			full_s1 <= (KW'(in_nx) >= cap_eff) && (out_nx != '0);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.data_out   <= rd_s1 ? signed'(rd_ext[31:0]) : 32'sd0;
			rsp_q.status     <= st_s1;
			rsp_q.item_count <= cnt_s1;
			rsp_q.is_full    <= full_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* tb/sv/two_stack_bounded_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_stack_bounded_queue_tb
// self-checking bench: a directed opening, then random phases at several
// stack capacities, each request predicted on acceptance and every response
// compared field by field in arrival order
// ----------------------------------------------------------------------------
module two_stack_bounded_queue_tb;
	import tsbq_pkg::*;

	localparam int STACK_DEPTH = DEF_STACK_DEPTH;
	localparam int MAX_REPORTS = 10;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data  = '0;

	// requests waiting to be driven, responses waiting to arrive
	req_t pending_req[$];
	rsp_t expected_rsp[$];

	// shadow of the queue: both stacks, their fill levels and the capacity
	logic signed [31:0] in_stack  [STACK_DEPTH];
	logic signed [31:0] out_stack [STACK_DEPTH];
	int unsigned        in_count       = 0;
	int unsigned        out_count      = 0;
	logic [CAP_W-1:0]   capacity_value = CAP_RESET;

	// when set, neither side idles nor stalls
	bit          steady        = 1'b0;
	int unsigned req_gap       = 0;
	int unsigned rsp_stall     = 0;
	int unsigned mismatch_count = 0;
	rsp_t        oldest_rsp;
	bit          field_bad;

	two_stack_bounded_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// inbound elements go over to the outbound stack in reversed order;
	// only ever done while the outbound stack is empty
	function automatic void transfer_stacks();
		while (in_count > 0 && out_count < STACK_DEPTH) begin
			in_count--;
			out_stack[out_count] = in_stack[in_count];
			out_count++;
		end
	endfunction

	// applies one request to the shadow queue and returns its response
	function automatic rsp_t queue_step(req_t r);
		rsp_t        res;
		int unsigned cap;
		bit          accept;
		res        = '0;
		res.status = ST_OK;
		// a capacity of zero or above the depth is saturated into range
		cap = (capacity_value == 0) ? 1 :
			(capacity_value > STACK_DEPTH) ? STACK_DEPTH : capacity_value;
		case (r.opcode)
			OP_PUSH: begin
				accept = 1'b1;
				// inbound counts as full at or above the capacity, which also
				// covers a capacity lowered below the current contents
				if (in_count >= cap) begin
					if (out_count != 0)
						accept = 1'b0;
					else
						transfer_stacks();
				end
				if (accept && in_count < STACK_DEPTH) begin
					in_stack[in_count] = r.push_value;
					in_count++;
				end else begin
					res.status = ST_FULL;
				end
			end
			OP_POP: begin
				// refill moves every inbound element, whatever the capacity
				if (out_count == 0)
					transfer_stacks();
				if (out_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					out_count--;
					res.data_out = out_stack[out_count];
				end
			end
			OP_READ: begin
				// fifo order: outbound top first, then inbound bottom up
				if (r.read_index >= in_count + out_count)
					res.status = ST_RANGE;
				else if (r.read_index < out_count)
					res.data_out = out_stack[out_count - r.read_index - 1];
				else
					res.data_out = in_stack[r.read_index - out_count];
			end
			default: ;
		endcase
		res.item_count = 8'(in_count + out_count);
		res.is_full    = (in_count >= cap) && (out_count != 0);
		return res;
	endfunction

	// mostly no gap, some short ones, a few long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 88)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// request driver: presents pending requests and predicts each one in the
	// cycle it is accepted
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			req_gap   = 0;
		end else begin
			if (req_valid && req_ready)
				expected_rsp.push_back(queue_step(req));
			// a new request may go out only once the current one is taken
			if (!req_valid || req_ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_req.size() > 0) begin
					req       <= pending_req.pop_front();
					req_valid <= 1'b1;
					req_gap   = steady ? 0 : pick_gap();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// response monitor: random back-pressure, checks against the oldest
	// expectation
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_stall = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: response with nothing expected:", $realtime,
							" data %0d status %0d count %0d full %0b",
							rsp.data_out, rsp.status, rsp.item_count, rsp.is_full);
					mismatch_count++;
				end else begin
					oldest_rsp = expected_rsp.pop_front();
					field_bad  = (rsp.data_out !== oldest_rsp.data_out) ||
						(rsp.status !== oldest_rsp.status) ||
						(rsp.item_count !== oldest_rsp.item_count) ||
						(rsp.is_full !== oldest_rsp.is_full);
					if (field_bad) begin
						if (mismatch_count < MAX_REPORTS)
							$display("%0t: mismatch: expected data %0d status %0d",
								$realtime, oldest_rsp.data_out, oldest_rsp.status,
								" count %0d full %0b,",
								oldest_rsp.item_count, oldest_rsp.is_full,
								" got data %0d status %0d count %0d full %0b",
								rsp.data_out, rsp.status, rsp.item_count, rsp.is_full);
						mismatch_count++;
					end
				end
			end
			if (rsp_stall > 0) begin
				rsp_stall--;
				rsp_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 25) begin
				rsp_stall = pick_gap();
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic add_req(op_t op, logic signed [31:0] value, logic [6:0] index);
		req_t r;
		r.opcode     = op;
		r.push_value = value;
		r.read_index = index;
		pending_req.push_back(r);
	endtask

	// queue drained of in-flight transactions, stacks themselves untouched;
	// sampled on the falling edge so the driver's updates have settled
	task automatic wait_idle();
		while (pending_req.size() != 0 || expected_rsp.size() != 0 || req_valid)
			@(negedge clk);
	endtask

	// capacity only changes with nothing in flight, after the pipeline settles
	task automatic set_capacity(logic [CAP_W-1:0] value);
		wait_idle();
		repeat (4) @(posedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		capacity_value = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t random_req(int unsigned push_pct);
		req_t        r;
		int unsigned roll;
		r.push_value = $urandom;
		roll = $urandom_range(0, 99);
		// reads mostly near the head, now and then anywhere in the index range
		if (roll < 60)
			r.read_index = $urandom_range(0, 7);
		else if (roll < 85)
			r.read_index = $urandom_range(0, 63);
		else
			r.read_index = $urandom_range(0, 127);
		if ($urandom_range(0, 99) < push_pct) begin
			r.opcode = OP_PUSH;
		end else begin
			roll = $urandom_range(0, 19);
			if (roll == 0)
				r.opcode = OP_NONE;
			else if (roll <= 10)
				r.opcode = OP_POP;
			else
				r.opcode = OP_READ;
		end
		return r;
	endfunction

	// contents carry over between phases, so a lower capacity meets a fuller
	// queue than it allows
	task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned count,
		int unsigned push_pct, bit no_idle);
		set_capacity(cap);
		steady = no_idle;
		repeat (count) pending_req.push_back(random_req(push_pct));
		wait_idle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed part with a capacity of four
		set_capacity(7'd4);
		add_req(OP_POP,  32'sd0, 7'd0);            // pop on empty
		add_req(OP_READ, 32'sd0, 7'd0);            // read on empty
		add_req(OP_NONE, 32'sd0, 7'd0);            // unused opcode
		add_req(OP_PUSH, 32'h7fffffff, 7'd0);
		add_req(OP_PUSH, 32'h80000000, 7'd0);
		add_req(OP_PUSH, 32'hffffffff, 7'd127);
		add_req(OP_PUSH, 32'sd0, 7'd0);             // inbound now at capacity
		add_req(OP_READ, 32'sd0, 7'd0);
		add_req(OP_READ, 32'sd0, 7'd3);
		add_req(OP_READ, 32'sd0, 7'd4);            // one past the end
		add_req(OP_READ, 32'hffffffff, 7'd127);
		add_req(OP_PUSH, 32'sd5, 7'd0);             // transfer, then push
		add_req(OP_PUSH, 32'sd6, 7'd0);
		add_req(OP_PUSH, 32'sd7, 7'd0);
		add_req(OP_PUSH, 32'sd8, 7'd0);             // both stacks hold four
		add_req(OP_PUSH, 32'sd9, 7'd0);             // rejected, queue full
		add_req(OP_READ, 32'sd0, 7'd5);            // inbound part
		add_req(OP_READ, 32'sd0, 7'd1);            // outbound part
		add_req(OP_POP,  32'sd0, 7'd0);
		add_req(OP_PUSH, 32'sd10, 7'd0);            // still rejected
		add_req(OP_POP,  32'sd0, 7'd0);
		add_req(OP_POP,  32'sd0, 7'd0);
		add_req(OP_POP,  32'sd0, 7'd0);
		add_req(OP_POP,  32'sd0, 7'd0);            // refill from inbound
		add_req(OP_NONE, 32'hffffffff, 7'd127);
		wait_idle();

		// random phases across the capacity range, extremes included
		run_phase(7'd1,   25,  50, 1'b0);
		run_phase(7'd0,   25,  50, 1'b0);
		run_phase(7'd2,   35,  55, 1'b1);
		run_phase(7'd127, 160, 95, 1'b0);          // fill to both stacks full
		run_phase(7'd64,  70,  20, 1'b0);          // mostly draining
		run_phase(7'd3,   35,  50, 1'b0);
		run_phase(7'd65,  25,  60, 1'b1);
		run_phase(7'($urandom_range(4, 16)), 35, 50, 1'b0);

		// let any stray response show up before the verdict
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_rsp.size() == 0) begin
			$display("two_stack_bounded_queue regression: pass");
		end else begin
			$display("two_stack_bounded_queue regression: fail");
		end
		$finish;
	end

	// run-time limit, far beyond the slowest correct run
	initial begin
		#5000000;
		$display("two_stack_bounded_queue regression: fail");
		$finish;
	end

endmodule
